[design/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the glyph table for the seven-segment scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

   // field and store widths
   localparam int DIGITS  = 4;
   localparam int POS_W   = 2;
   localparam int DIGIT_W = 4;
   localparam int VALUE_W = 7;
   localparam int SEL_W   = 4;
   localparam int SEG_W   = 8;
   localparam int SLOW_W  = 6;
   localparam int CMD_W   = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SCAN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SLOW = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

   // display constants
   localparam logic [VALUE_W-1:0] VALUE_MAX     = 7'd99;
   localparam logic [SLOW_W-1:0]  SLOW_LAST     = 6'd39;
   localparam logic [SEG_W-1:0]   POINT_MASK    = 8'h20;
   localparam logic [SEG_W-1:0]   BLANK_PATTERN = 8'h00;
   localparam logic [POS_W-1:0]   POS_LEAD      = 2'd0;
   localparam logic [POS_W-1:0]   POS_POINT     = 2'd1;

   // input item
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;
   } req_type;

   // result item
   typedef struct packed {
      logic [SEL_W-1:0] digit_select;
      logic [SEG_W-1:0] segment_drive;
      logic             refresh_request;
   } rsp_type;

   // per-item strobes, high in the cycle the item is processed
   typedef struct packed {
      logic scan;
      logic slow;
      logic load;
   } step_type;

   // active-high segment pattern of a decimal digit, C G point D E B F A
   function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 8'b10011111;
         4'd1:    p = 8'b10000100;
         4'd2:    p = 8'b01011101;
         4'd3:    p = 8'b11010101;
         4'd4:    p = 8'b11000110;
         4'd5:    p = 8'b11010011;
         4'd6:    p = 8'b11011011;
         4'd7:    p = 8'b10000101;
         4'd8:    p = 8'b11011111;
         default: p = 8'b11010111;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[design/seven_segment_scan_driver_core.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_core
// Four-digit multiplexed seven-segment scan driver.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one item per handshake: a scan tick, a slow tick, or a
//   load of two values 0..99 (larger values show as 99).
//   rsp channel returns exactly one item per request, in order: the current
//   one-hot digit enable, its active-low segments and the refresh flag.
//   A scan tick advances the digit and updates the drive; other items
//   return the drive unchanged.
// Timing:
//   a request passes the input register, then the result register; one
//   item per cycle is sustained while rsp_ready stays high.
// Reset:
//   synchronous; clears digits, scan position, blink flag, slow count and
//   the held drive (digit enable and segments read as zero).
// Stall:
//   a result waiting on rsp_ready holds; one more item can sit in the input
//   register, after which req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ssd_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ssd_pkg::rsp_type      rsp_item
);

   logic                        stage_valid;
   ssd_pkg::req_type            stage_item;
   logic                        advance;
   ssd_pkg::step_type           step;
   logic [ssd_pkg::SEG_W-1:0]   pattern;
   logic                        point_on;
   logic                        refresh;

   logic [ssd_pkg::POS_W-1:0]   pos_ff;
   logic [ssd_pkg::POS_W-1:0]   pos_in;
   logic [ssd_pkg::SEL_W-1:0]   held_select_ff;
   logic [ssd_pkg::SEL_W-1:0]   held_select_in;
   logic [ssd_pkg::SEG_W-1:0]   held_segments_ff;
   logic [ssd_pkg::SEG_W-1:0]   held_segments_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   ssd_pkg::rsp_type            rsp_item_ff;
   ssd_pkg::rsp_type            rsp_item_in;

   ssd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   // item moves on when the result slot is free or being emptied
   assign advance   = stage_valid && (!rsp_valid_ff || rsp_ready);
   assign step.scan = advance && stage_item.cmd == ssd_pkg::CMD_SCAN;
   assign step.slow = advance && stage_item.cmd == ssd_pkg::CMD_SLOW;
   assign step.load = advance && stage_item.cmd == ssd_pkg::CMD_LOAD;

   ssd_digit_store u_digit_store (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .left_value  (stage_item.left_value),
      .right_value (stage_item.right_value),
      .pos         (pos_ff),
      .point_on    (point_on),
      .pattern     (pattern)
   );

   ssd_slow_timer u_slow_timer (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .point_on (point_on),
      .refresh  (refresh)
   );

   // scan position and held drive
   always_comb begin
      pos_in           = pos_ff;
      held_select_in   = held_select_ff;
      held_segments_in = held_segments_ff;
      if (step.scan) begin
         held_select_in   = ssd_pkg::SEL_W'(1) << pos_ff;
         held_segments_in = ~pattern;
         pos_in           = pos_ff + 2'd1;
      end
   end

   // result register
   always_comb begin
      rsp_item_in.digit_select    = held_select_in;
      rsp_item_in.segment_drive   = held_segments_in;
      rsp_item_in.refresh_request = refresh;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         held_select_ff   <= '0;
         held_segments_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         held_select_ff   <= held_select_in;
         held_segments_ff <= held_segments_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // after a scan tick exactly the previous position is enabled
   a_scan_select: assert property (@(posedge clock) disable iff (reset)
      step.scan |=> $onehot(held_select_ff) &&
                    held_select_ff == ssd_pkg::SEL_W'(1) << $past(pos_ff))
      else $error("scan tick drove wrong digit enable");

   // the held drive never enables two digits
   a_select_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(held_select_ff))
      else $error("more than one digit enabled");
`endif

endmodule

`default_nettype wire

[design/ssd_in_stage.sv]
// ----------------------------------------------------------------------------
// ssd_in_stage
// Input register: holds one accepted item until the result side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ssd_pkg::req_type req_item,
   input  wire logic            advance,
   output logic                 stage_valid,
   output ssd_pkg::req_type     stage_item
);

   logic             valid_ff;
   logic             valid_in;
   ssd_pkg::req_type item_ff;
   logic             accept;

   // free when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

`ifndef NO_ASSERTIONS
   // an item only moves on when one is held
   a_advance_held: assert property (@(posedge clock) disable iff (reset)
      advance |-> valid_ff)
      else $error("advance without a held item");
`endif

endmodule

`default_nettype wire

[design/ssd_digit_store.sv]
// ----------------------------------------------------------------------------
// ssd_digit_store
// Holds the four display digits and looks up the pattern of one position.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_digit_store (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ssd_pkg::step_type              step,
   input  wire logic [ssd_pkg::VALUE_W-1:0]    left_value,
   input  wire logic [ssd_pkg::VALUE_W-1:0]    right_value,
   input  wire logic [ssd_pkg::POS_W-1:0]      pos,
   input  wire logic                           point_on,
   output logic [ssd_pkg::SEG_W-1:0]           pattern
);

   logic [ssd_pkg::DIGIT_W-1:0] digits_ff [ssd_pkg::DIGITS];
   logic [ssd_pkg::DIGIT_W-1:0] digits_in [ssd_pkg::DIGITS];
   logic [2*ssd_pkg::DIGIT_W-1:0] left_split;
   logic [2*ssd_pkg::DIGIT_W-1:0] right_split;
   logic [ssd_pkg::DIGIT_W-1:0] cur_digit;
   logic [ssd_pkg::SEG_W-1:0]   lit;

   // clamp to 99, then tens by reciprocal multiply (exact for any 7-bit value)
   function automatic logic [2*ssd_pkg::DIGIT_W-1:0] split(
      input logic [ssd_pkg::VALUE_W-1:0] value);
      logic [ssd_pkg::VALUE_W-1:0]   v;
      logic [14:0]                   prod;
      logic [ssd_pkg::DIGIT_W-1:0]   tens;
      logic [ssd_pkg::VALUE_W-1:0]   units;
      v     = (value > ssd_pkg::VALUE_MAX) ? ssd_pkg::VALUE_MAX : value;
      prod  = 15'(v) * 15'd205;
      tens  = prod[14:11];
      units = v - 7'(tens) * 7'd10;
      return {tens, units[ssd_pkg::DIGIT_W-1:0]};
   endfunction

   assign left_split  = split(left_value);
   assign right_split = split(right_value);

   // load writes all four digits
   always_comb begin
      for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (step.load) begin
         digits_in[0] = left_split[2*ssd_pkg::DIGIT_W-1:ssd_pkg::DIGIT_W];
         digits_in[1] = left_split[ssd_pkg::DIGIT_W-1:0];
         digits_in[2] = right_split[2*ssd_pkg::DIGIT_W-1:ssd_pkg::DIGIT_W];
         digits_in[3] = right_split[ssd_pkg::DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

   // pattern lookup with leading blank and blinking point
   assign cur_digit = digits_ff[pos];

   always_comb begin
      lit = ssd_pkg::glyph(cur_digit);
      if (pos == ssd_pkg::POS_POINT && point_on) begin
         lit = lit | ssd_pkg::POINT_MASK;
      end
      if (pos == ssd_pkg::POS_LEAD && cur_digit == '0) begin
         lit = ssd_pkg::BLANK_PATTERN;
      end
   end

   assign pattern = lit;

`ifndef NO_ASSERTIONS
   // stored digits are always decimal
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      digits_ff[0] <= 4'd9 && digits_ff[1] <= 4'd9 &&
      digits_ff[2] <= 4'd9 && digits_ff[3] <= 4'd9)
      else $error("stored digit above nine");
`endif

endmodule

`default_nettype wire

[design/ssd_slow_timer.sv]
// ----------------------------------------------------------------------------
// ssd_slow_timer
// Modulo-40 slow tick counter with blink flag and refresh request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_slow_timer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ssd_pkg::step_type step,
   output logic                  point_on,
   output logic                  refresh
);

   logic [ssd_pkg::SLOW_W-1:0] count_ff;
   logic [ssd_pkg::SLOW_W-1:0] count_in;
   logic                       point_ff;
   logic                       point_in;
   logic                       at_zero;

   assign at_zero = (count_ff == '0);

   // refresh on counts 0, 10, 20 and 30
   assign refresh = step.slow && (at_zero || count_ff == 6'd10 ||
                                  count_ff == 6'd20 || count_ff == 6'd30);

   always_comb begin
      count_in = count_ff;
      point_in = point_ff;
      if (step.slow) begin
         count_in = (count_ff >= ssd_pkg::SLOW_LAST) ? '0 : count_ff + 6'd1;
         if (at_zero) begin
            point_in = !point_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         point_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         point_ff <= point_in;
      end
   end

   assign point_on = point_ff;

`ifndef NO_ASSERTIONS
   // count stays within 0..39
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssd_pkg::SLOW_LAST)
      else $error("slow count out of range");

   // blink flag changes only on a slow tick at count zero
   a_point_toggle: assert property (@(posedge clock) disable iff (reset)
      !(step.slow && at_zero) |=> $stable(point_ff))
      else $error("blink flag changed outside count zero");
`endif

endmodule

`default_nettype wire
